// ----- rtl/sfdt_pkg.sv -----
// Package for the scaled fixed-point to decimal text core.
// Holds the controller/datapath types, character codes and constant tables.
// No dependencies.
`timescale 1ns / 1ps

package sfdt_pkg;

  // Fixed-point constants
  localparam logic [19:0] FX_HALF       = 20'h08000;
  localparam logic [19:0] FX_ROUND_SUB  = 20'd50000;
  localparam logic [19:0] FX_ROUND_ADJ  = FX_ROUND_SUB - FX_HALF;
  localparam logic [19:0] FX_FRAC_BIAS  = 20'd5;

  // Digit positions of the integer part (10000 down to 1)
  localparam logic [2:0] INT_LAST_POS   = 3'd4;
  // Fraction step at which the rounding correction applies, also the final step
  localparam logic [2:0] FRAC_ROUND_STEP = 3'd4;

  // ASCII codes
  localparam logic [6:0] CHAR_MINUS = 7'h2d;
  localparam logic [6:0] CHAR_DOT   = 7'h2e;
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_P     = 7'h70;
  localparam logic [6:0] CHAR_T     = 7'h74;
  localparam logic [6:0] CHAR_F     = 7'h66;
  localparam logic [6:0] CHAR_I     = 7'h69;
  localparam logic [6:0] CHAR_L     = 7'h6c;

  // Unit orders
  localparam logic [2:0] ORDER_PT    = 3'd0;
  localparam logic [2:0] ORDER_FIL   = 3'd1;
  localparam logic [2:0] ORDER_FILL  = 3'd2;
  localparam logic [2:0] ORDER_FILLL = 3'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIGN,
    ST_INT,
    ST_DOT,
    ST_FRAC,
    ST_SUF
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SIGN,
    OP_INT,
    OP_DOT,
    OP_FRAC,
    OP_SUF
  } op_e;

  typedef struct packed {
    logic load;
    op_e  op;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic neg;
    logic int_end;
    logic frac_end;
    logic has_suffix;
    logic suf_end;
  } status_t;

  // Place value of integer digit position pos
  function automatic logic [16:0] int_pow(input logic [2:0] pos);
    logic [16:0] p;
    case (pos)
      3'd0:    p = 17'd10000;
      3'd1:    p = 17'd1000;
      3'd2:    p = 17'd100;
      3'd3:    p = 17'd10;
      default: p = 17'd1;
    endcase
    return p;
  endfunction

  // Rounding window after fraction step k
  function automatic logic [19:0] frac_delta(input logic [2:0] k);
    logic [19:0] d;
    case (k)
      3'd0:    d = 20'd100;
      3'd1:    d = 20'd1000;
      3'd2:    d = 20'd10000;
      3'd3:    d = 20'd100000;
      default: d = 20'd1000000;
    endcase
    return d;
  endfunction

  function automatic logic [2:0] suffix_last_idx(input logic [2:0] order);
    logic [2:0] n;
    case (order)
      ORDER_PT:    n = 3'd1;
      ORDER_FIL:   n = 3'd2;
      ORDER_FILL:  n = 3'd3;
      ORDER_FILLL: n = 3'd4;
      default:     n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [6:0] suffix_char(input logic [2:0] order,
                                             input logic [2:0] idx);
    logic [6:0] c;
    if (order == ORDER_PT) begin
      c = (idx == 3'd0) ? CHAR_P : CHAR_T;
    end else begin
      case (idx)
        3'd0:    c = CHAR_F;
        3'd1:    c = CHAR_I;
        default: c = CHAR_L;
      endcase
    end
    return c;
  endfunction

endpackage

// ----- rtl/scaled_fixed_to_decimal_text_core.sv -----
// Top level of the scaled fixed-point to decimal text core.
// Instantiates sfdt_ctrl and sfdt_dp; types come from sfdt_pkg.
`timescale 1ns / 1ps

// Prints a signed 16.16 fixed-point value as ASCII text, one character per
// strobe: optional '-', integer digits, '.', the shortest fraction (one to
// five digits, classic round-trip rounding) and a unit suffix "pt", "fil",
// "fill" or "filll" for unit orders 0..3 (none for 4..7). last_char_o marks
// the final character of each value. A transaction is taken when start_i is
// high and busy_o is low. Characters leave on char_strobe_o for exactly one
// cycle each and cannot be stalled: the receiver must take every strobe.
// A negative value shows its '-' first; a positive value shows its first
// digit later the fewer integer digits it has. The sequencer steps through
// the sign slot, each of the five integer digit positions (leading zeros
// take a step but give no strobe), the point, each fraction digit and each
// suffix letter, so strobes may be spaced by gaps in the sign and integer
// phases. busy_o drops in the cycle the last character is shown, so the
// next start can be taken then. Digit extraction uses one compare bank
// against multiples of the place value per cycle; the fraction uses one
// times-ten step per cycle.

module scaled_fixed_to_decimal_text_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] value_i,
  input  logic [2:0]  unit_order_i,
  output logic [6:0]  text_char_o,
  output logic        last_char_o,
  output logic        char_strobe_o
);

  // command and status between sequencer and datapath
  sfdt_pkg::cmd_t    cmd;
  sfdt_pkg::status_t status;

  sfdt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  sfdt_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (value_i),
    .unit_order_i  (unit_order_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .text_char_o   (text_char_o),
    .last_char_o   (last_char_o),
    .char_strobe_o (char_strobe_o)
  );

endmodule

// ----- rtl/sfdt_ctrl.sv -----
// Controller FSM of the decimal text core: sequences sign, integer,
// point, fraction and suffix phases. Depends on sfdt_pkg.
`timescale 1ns / 1ps

module sfdt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  sfdt_pkg::status_t status_i,
  output sfdt_pkg::cmd_t   cmd_o,
  output logic             busy_o
);

  sfdt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfdt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.op   = sfdt_pkg::OP_NONE;
    cmd_o.last = 1'b0;
    case (state_q)
      sfdt_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = sfdt_pkg::ST_SIGN;
        end
      end
      sfdt_pkg::ST_SIGN: begin
        // sign flag is valid once loaded; positive values skip straight on
        if (status_i.neg) begin
          cmd_o.op = sfdt_pkg::OP_SIGN;
        end
        state_d = sfdt_pkg::ST_INT;
      end
      sfdt_pkg::ST_INT: begin
        cmd_o.op = sfdt_pkg::OP_INT;
        if (status_i.int_end) begin
          state_d = sfdt_pkg::ST_DOT;
        end
      end
      sfdt_pkg::ST_DOT: begin
        cmd_o.op = sfdt_pkg::OP_DOT;
        state_d  = sfdt_pkg::ST_FRAC;
      end
      sfdt_pkg::ST_FRAC: begin
        cmd_o.op = sfdt_pkg::OP_FRAC;
        if (status_i.frac_end) begin
          cmd_o.last = !status_i.has_suffix;
          state_d    = status_i.has_suffix ? sfdt_pkg::ST_SUF : sfdt_pkg::ST_IDLE;
        end
      end
      sfdt_pkg::ST_SUF: begin
        cmd_o.op = sfdt_pkg::OP_SUF;
        if (status_i.suf_end) begin
          cmd_o.last = 1'b1;
          state_d    = sfdt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sfdt_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != sfdt_pkg::ST_IDLE);

endmodule

// ----- rtl/sfdt_dp.sv -----
// Datapath of the decimal text core: magnitude, integer digit extraction,
// fraction digit generation, suffix lookup and output register. Uses sfdt_pkg.
`timescale 1ns / 1ps

module sfdt_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [31:0]       value_i,
  input  logic [2:0]        unit_order_i,
  input  sfdt_pkg::cmd_t    cmd_i,
  output sfdt_pkg::status_t status_o,
  output logic [6:0]        text_char_o,
  output logic              last_char_o,
  output logic              char_strobe_o
);

  logic        neg_q;
  logic [2:0]  order_q;
  logic [15:0] ip_q, ip_d;
  logic [2:0]  pos_q;
  logic        started_q;
  logic [19:0] s_q;
  logic [2:0]  k_q;
  logic [2:0]  sidx_q;
  logic [6:0]  char_q, char_d;
  logic        last_q;
  logic        emit_q, emit_d;

  logic [31:0] mag;
  logic [19:0] frac_ext;
  logic [19:0] s_init;

  logic [16:0] pow;
  logic [16:0] thr [10];
  logic [3:0]  idig;
  logic        int_skip;

  logic [19:0] s_adj;
  logic [19:0] s_lo;
  logic [19:0] s_next;
  logic [6:0]  fdig;

  // load-time magnitude and first fraction term 10*f + 5
  assign mag      = value_i[31] ? (32'd0 - value_i) : value_i;
  assign frac_ext = {4'd0, mag[15:0]};
  assign s_init   = (frac_ext << 3) + (frac_ext << 1) + sfdt_pkg::FX_FRAC_BIAS;

  // integer digit: compare remainder against multiples of the place value
  always_comb begin
    pow    = sfdt_pkg::int_pow(pos_q);
    thr[0] = 17'd0;
    idig   = 4'd0;
    for (int m = 1; m < 10; m++) begin
      thr[m] = 17'(m) * pow;
    end
    for (int m = 1; m < 10; m++) begin
      if ({1'b0, ip_q} >= thr[m]) begin
        idig = 4'(m);
      end
    end
    ip_d = ip_q - thr[idig][15:0];
  end

  assign int_skip = (idig == 4'd0) && !started_q && (pos_q != sfdt_pkg::INT_LAST_POS);

  // fraction step
  assign s_adj  = (k_q == sfdt_pkg::FRAC_ROUND_STEP) ? (s_q - sfdt_pkg::FX_ROUND_ADJ) : s_q;
  assign s_lo   = {4'd0, s_adj[15:0]};
  assign s_next = (s_lo << 3) + (s_lo << 1);
  assign fdig   = {3'd0, s_adj[19:16]};

  assign status_o.neg        = neg_q;
  assign status_o.int_end    = (pos_q == sfdt_pkg::INT_LAST_POS);
  assign status_o.frac_end   = (s_next <= sfdt_pkg::frac_delta(k_q)) ||
                               (k_q == sfdt_pkg::FRAC_ROUND_STEP);
  assign status_o.has_suffix = (order_q <= sfdt_pkg::ORDER_FILLL);
  assign status_o.suf_end    = (sidx_q == sfdt_pkg::suffix_last_idx(order_q));

  always_comb begin
    emit_d = 1'b1;
    case (cmd_i.op)
      sfdt_pkg::OP_SIGN: char_d = sfdt_pkg::CHAR_MINUS;
      sfdt_pkg::OP_INT: begin
        char_d = sfdt_pkg::CHAR_ZERO + {3'd0, idig};
        emit_d = !int_skip;
      end
      sfdt_pkg::OP_DOT:  char_d = sfdt_pkg::CHAR_DOT;
      sfdt_pkg::OP_FRAC: char_d = sfdt_pkg::CHAR_ZERO + fdig;
      sfdt_pkg::OP_SUF:  char_d = sfdt_pkg::suffix_char(order_q, sidx_q);
      default: begin
        char_d = sfdt_pkg::CHAR_ZERO;
        emit_d = 1'b0;
      end
    endcase
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q     <= value_i[31];
      order_q   <= unit_order_i;
      ip_q      <= mag[31:16];
      pos_q     <= 3'd0;
      started_q <= 1'b0;
      s_q       <= s_init;
      k_q       <= 3'd0;
      sidx_q    <= 3'd0;
    end else begin
      case (cmd_i.op)
        sfdt_pkg::OP_INT: begin
          ip_q      <= ip_d;
          pos_q     <= pos_q + 3'd1;
          started_q <= started_q || (idig != 4'd0);
        end
        sfdt_pkg::OP_FRAC: begin
          s_q <= s_next;
          k_q <= k_q + 3'd1;
        end
        sfdt_pkg::OP_SUF: sidx_q <= sidx_q + 3'd1;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q <= 1'b0;
      last_q <= 1'b0;
    end else begin
      emit_q <= emit_d;
      last_q <= emit_d && cmd_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

  assign text_char_o   = char_q;
  assign last_char_o   = last_q;
  assign char_strobe_o = emit_q;

endmodule

// ----- rtl/sfdt_checker.sv -----
// Port-level checker for the decimal text core, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module sfdt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic [6:0] text_char_o,
  input logic       last_char_o,
  input logic       char_strobe_o
);

  // an accepted transaction always occupies the core
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("core not busy after start");

  // the final character of a value releases the core
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_strobe_o && last_char_o |-> !busy_o)
    else $error("core still busy on last character");

  // an idle core with nothing in flight emits nothing
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o && !$past(busy_o) |-> !char_strobe_o)
    else $error("strobe while idle");

  // output characters are within the printed set
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_strobe_o |-> (text_char_o >= 7'h2d) && (text_char_o <= 7'h74))
    else $error("character out of range");

endmodule

bind scaled_fixed_to_decimal_text_core sfdt_checker u_sfdt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .text_char_o   (text_char_o),
  .last_char_o   (last_char_o),
  .char_strobe_o (char_strobe_o)
);

// ----- tb/tb.sv -----
// Self-checking bench for scaled_fixed_to_decimal_text_core.
// Predicts the character run of each value and checks every strobe in order.
// Depends on sfdt_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb;

  // Unit orders with no suffix (four up to seven)
  localparam logic [2:0] ORDER_BARE     = 3'd4;
  localparam logic [2:0] ORDER_BARE_MAX = 3'd7;

  // Cycles with no transaction on either side before the run is abandoned
  localparam int unsigned STALL_LIMIT = 3000;
  // Drain time after the last expected character
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_VALUES = 189;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  order;
  } fx_item_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } text_char_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [31:0] value_i = '0;
  logic [2:0]  unit_order_i = '0;
  logic        busy_o;
  logic [6:0]  text_char_o;
  logic        last_char_o;
  logic        char_strobe_o;

  fx_item_t    pending_values[$];
  text_char_t  expected_text[$];
  int unsigned fail_count = 0;
  int unsigned values_taken = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sender_idle_pct;
  logic        value_taken = 1'b0;
  logic        stray_char;

  scaled_fixed_to_decimal_text_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .value_i       (value_i),
    .unit_order_i  (unit_order_i),
    .text_char_o   (text_char_o),
    .last_char_o   (last_char_o),
    .char_strobe_o (char_strobe_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Prints a 16.16 value the classic way: sign, integer digits, point, the
  // shortest fraction that reads back to the same value, then the suffix.
  task automatic predict_text(input logic [31:0] value, input logic [2:0] order);
    logic [6:0]  line[$];
    logic [6:0]  int_digits[$];
    int unsigned mag;
    int unsigned ipart;
    int unsigned scaled;
    int unsigned window;
    mag = value;
    if (value[31]) begin
      line.push_back(sfdt_pkg::CHAR_MINUS);
      // unsigned negate, so the most negative value gives 32768 cleanly
      mag = 32'd0 - value;
    end
    ipart = mag >> 16;
    do begin
      int_digits.push_front(sfdt_pkg::CHAR_ZERO + 7'(ipart % 10));
      ipart = ipart / 10;
    end while (ipart != 0);
    foreach (int_digits[i]) line.push_back(int_digits[i]);
    line.push_back(sfdt_pkg::CHAR_DOT);
    // fraction: digit by digit, stop once the remainder is inside the window
    scaled = 10 * (mag & 32'hffff) + 5;
    window = 10;
    do begin
      if (window > 32'h10000) scaled = scaled + 32'h8000 - 50000;
      line.push_back(sfdt_pkg::CHAR_ZERO + 7'((scaled / 32'h10000) % 10));
      scaled = 10 * (scaled & 32'hffff);
      window = window * 10;
    end while (scaled > window && window <= 1000000);
    case (order)
      sfdt_pkg::ORDER_PT: begin
        line.push_back(sfdt_pkg::CHAR_P);
        line.push_back(sfdt_pkg::CHAR_T);
      end
      sfdt_pkg::ORDER_FIL, sfdt_pkg::ORDER_FILL, sfdt_pkg::ORDER_FILLL: begin
        line.push_back(sfdt_pkg::CHAR_F);
        line.push_back(sfdt_pkg::CHAR_I);
        line.push_back(sfdt_pkg::CHAR_L);
        if (order != sfdt_pkg::ORDER_FIL) line.push_back(sfdt_pkg::CHAR_L);
        if (order == sfdt_pkg::ORDER_FILLL) line.push_back(sfdt_pkg::CHAR_L);
      end
      default: begin
      end
    endcase
    foreach (line[i]) expected_text.push_back('{ch: line[i], last: (i == line.size() - 1)});
  endtask

  // Random value, shaped so that short fractions, small integer parts and
  // the extremes all show up, not just uniformly random bit patterns.
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    int unsigned tenths;
    case ($urandom_range(0, 4))
      0: v = $urandom();
      // small integer part, random fraction
      1: v = {16'($urandom_range(0, 99)), 16'($urandom())};
      // fraction close to an exact decimal with up to four places
      2: begin
        tenths = $urandom_range(0, 9999);
        v = {16'($urandom_range(0, 999)), 16'((tenths * 65536 + 5000) / 10000)};
      end
      // tiny fraction only: exercises the full five digits
      3: v = {16'h0000, 16'($urandom_range(0, 15))};
      default: v = {$urandom_range(0, 1) ? 16'h7fff : 16'h8000, 16'($urandom())};
    endcase
    if ($urandom_range(0, 2) == 0) v = 32'd0 - v;
    return v;
  endfunction

  // Driver: new inputs at the falling edge. A value stays up until the rising
  // edge that takes it (start high, busy low), then the next one follows or
  // start drops while the sender idles.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!start_i || value_taken) begin
      if (pending_values.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        fx_item_t nxt;
        nxt = pending_values.pop_front();
        start_i      <= 1'b1;
        value_i      <= nxt.value;
        unit_order_i <= nxt.order;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Sender idling by phase: light, then heavy, then none at all
  always_comb begin
    if (values_taken < 80) sender_idle_pct = 13;
    else if (values_taken < 160) sender_idle_pct = 87;
    else sender_idle_pct = 0;
  end

  // Monitor: at each rising edge check the strobe first, so a character still
  // in flight is matched before a value taken at the same edge adds its text.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      stray_char = char_strobe_o && (expected_text.size() == 0);
      if (char_strobe_o) begin
        if (expected_text.size() == 0) begin
          $error("unexpected character: text_char actual %h last_char actual %b",
                 text_char_o, last_char_o);
          fail_count++;
        end else begin
          text_char_t exp_char;
          exp_char = expected_text.pop_front();
          if (text_char_o !== exp_char.ch) begin
            $error("text_char mismatch: expected %h actual %h", exp_char.ch, text_char_o);
            fail_count++;
          end
          if (last_char_o !== exp_char.last) begin
            $error("last_char mismatch: expected %b actual %b", exp_char.last, last_char_o);
            fail_count++;
          end
        end
      end
      value_taken <= start_i && !busy_o;
      if (start_i && !busy_o) begin
        predict_text(value_i, unit_order_i);
        values_taken++;
      end
      // watchdog on transactions in either direction; characters beyond the
      // predicted text do not count, so a runaway core still ends the run
      if ((start_i && !busy_o) || (char_strobe_o && !stray_char)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    // directed: extremes, integer widths of one, two, three and five digits, every order, short and long fractions
    pending_values.push_back('{32'h0000_0000, sfdt_pkg::ORDER_PT});
    pending_values.push_back('{32'h7fff_ffff, ORDER_BARE_MAX});
    pending_values.push_back('{32'h8000_0000, sfdt_pkg::ORDER_PT});  // most negative value
    pending_values.push_back('{32'h8000_0000, ORDER_BARE});
    pending_values.push_back('{32'h8000_0001, sfdt_pkg::ORDER_FILLL});
    pending_values.push_back('{32'hffff_ffff, sfdt_pkg::ORDER_FIL});
    pending_values.push_back('{32'h0001_0000, sfdt_pkg::ORDER_FILL});
    pending_values.push_back('{32'h0000_ffff, sfdt_pkg::ORDER_FILLL});
    pending_values.push_back('{32'h0000_8000, ORDER_BARE});
    pending_values.push_back('{32'h0000_0001, ORDER_BARE + 3'd1});
    pending_values.push_back('{32'h0000_1999, ORDER_BARE + 3'd2});
    pending_values.push_back('{32'h0000_0002, sfdt_pkg::ORDER_PT});
    pending_values.push_back('{32'h7fff_0000, sfdt_pkg::ORDER_FIL});
    pending_values.push_back('{32'h3039_4000, sfdt_pkg::ORDER_FILL});   // 12345.25
    pending_values.push_back('{32'h03e7_c000, sfdt_pkg::ORDER_FILLL});  // 999.75
    pending_values.push_back('{32'h0063_0001, sfdt_pkg::ORDER_PT});
    pending_values.push_back('{32'h0009_fffe, ORDER_BARE});
    pending_values.push_back('{32'hfff6_0000, sfdt_pkg::ORDER_FIL});    // -10.0
    pending_values.push_back('{32'h0000_0a3d, sfdt_pkg::ORDER_PT});     // near 0.04
    pending_values.push_back('{32'h5555_5555, ORDER_BARE_MAX});
    pending_values.push_back('{32'haaaa_aaaa, sfdt_pkg::ORDER_FILL});
    for (int unsigned n = 0; n < RANDOM_VALUES; n++) begin
      pending_values.push_back('{pick_value(), 3'($urandom_range(0, 7))});
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // every value handed over, then every character seen
    while (pending_values.size() > 0 || start_i || expected_text.size() > 0) begin
      @(posedge clk_i);
    end
    // let any stray strobe show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sfdt_pkg.sv
rtl/sfdt_ctrl.sv
rtl/sfdt_dp.sv
rtl/scaled_fixed_to_decimal_text_core.sv
rtl/sfdt_checker.sv
tb/tb.sv
